/* src/u8sid_pkg.sv */
// Shared types, defaults and the lead-byte decode for the UTF-8 stream indexer.
// No dependencies; imported by every module of the block.
package u8sid_pkg;

  localparam int JUMP_STEP_DEF = 8;
  localparam int MAX_BYTES_DEF = 65536;

  localparam logic [7:0] ASCII_LIMIT  = 8'h80;
  localparam logic [7:0] LEAD2_LOW    = 8'hC2;
  localparam logic [7:0] LEAD3_LOW    = 8'hE0;
  localparam logic [7:0] LEAD4_LOW    = 8'hF0;
  localparam logic [7:0] LEAD_INV_LOW = 8'hF5;
  localparam logic [7:0] CONT_MASK    = 8'h3F;
  localparam logic [7:0] LEAD2_MASK   = 8'h1F;
  localparam logic [7:0] LEAD3_MASK   = 8'h0F;
  localparam logic [7:0] LEAD4_MASK   = 8'h07;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_1    = 3'd1;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  typedef struct packed {
    logic [2:0] len;
    logic       bad;
  } lead_info_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [15:0] code_point_index;
    logic [15:0] start_offset;
    logic        jump_mark;
    logic        invalid_lead;
    logic        truncated;
    logic        string_end;
    logic [16:0] total_code_points;
    logic        all_ascii;
    logic        count_saturated;
  } u8sid_res_t;

  function automatic lead_info_t lead_decode(input logic [7:0] b);
    lead_info_t li;
    li.bad = 1'b0;
    if (b < ASCII_LIMIT) begin
      li.len = LEN_1;
    end else if (b < LEAD2_LOW) begin
      li.len = LEN_1;
      li.bad = 1'b1;
    end else if (b < LEAD3_LOW) begin
      li.len = LEN_2;
    end else if (b < LEAD4_LOW) begin
      li.len = LEN_3;
    end else if (b < LEAD_INV_LOW) begin
      li.len = LEN_4;
    end else begin
      li.len = LEN_1;
      li.bad = 1'b1;
    end
    return li;
  endfunction

endpackage

/* src/utf8_stream_indexer_decoder_unit.sv */
// Top level of the UTF-8 stream indexer: input register, decode stage, result buffer.
// Depends on u8sid_pkg, u8sid_decode and u8sid_outq.
//
// Usage:
//   The string arrives one byte per transfer on the in_ channel (tdata[7:0] is
//   the byte, tlast marks the final byte). Each completed code point, and the
//   final byte of a string, yields one transfer on the out_ channel; bytes in
//   the middle of a multi-byte sequence yield none. out_tlast marks the result
//   of the final byte, which also carries the total count and the ASCII flag.
//   Throughput: one byte per cycle while the result buffer has space, set by
//   the single decode stage that reads the input register and writes the
//   two-entry result buffer. An accepted byte is held in the input register;
//   the decode stage then writes its result into the result buffer, which
//   raises out_tvalid, and the result can transfer from there.
//   Stall: when the receiver holds out_tready low the buffer fills; with two
//   results waiting the decode stage holds and in_tready falls once the input
//   register is also occupied. Nothing is dropped.
//   Reset: rst_n low clears all counters and the open sequence, empties the
//   buffer and the input register; the first byte afterward opens a string.
module utf8_stream_indexer_decoder_unit #(
  parameter int JUMP_STEP = u8sid_pkg::JUMP_STEP_DEF,
  parameter int MAX_BYTES = u8sid_pkg::MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [20:0] code_point, [36:21] code_point_index, [52:37] start_offset,
  // [69:53] total_code_points, [70] all_ascii, [71] count_saturated
  output logic [71:0] out_tdata,
  output logic [2:0]  out_tuser,  // [0] jump_mark, [1] invalid_lead, [2] truncated
  output logic        out_tlast   // string_end
);
  import u8sid_pkg::*;

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       q_space, fire, emit;
  u8sid_res_t dec_res, q_res;

  assign fire      = in_v_r && q_space;
  assign in_tready = !in_v_r || q_space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  u8sid_decode #(
    .JUMP_STEP (JUMP_STEP),
    .MAX_BYTES (MAX_BYTES)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .emit      (emit),
    .res       (dec_res)
  );

  u8sid_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire && emit),
    .push_res  (dec_res),
    .space     (q_space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (q_res)
  );

  assign out_tdata = {q_res.count_saturated, q_res.all_ascii, q_res.total_code_points,
                      q_res.start_offset, q_res.code_point_index, q_res.code_point};
  assign out_tuser = {q_res.truncated, q_res.invalid_lead, q_res.jump_mark};
  assign out_tlast = q_res.string_end;

  // a byte waiting on a full buffer must stay in the input register
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !q_space |=> in_v_r && $stable(in_byte_r) && $stable(in_last_r))
    else $error("stalled input byte lost");

  // an invalid lead is a lone raw byte, never a cut-short sequence
  a_invalid_raw: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[20:8] == 13'd0 && !out_tuser[2])
    else $error("invalid lead result malformed");

  // end-of-string fields stay zero before the last byte
  a_total_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[69:53] == 17'd0 && !out_tdata[70])
    else $error("string totals reported mid-string");

  a_jump_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[36:21] != 16'd0)
    else $error("jump mark on first code point");

endmodule

/* src/u8sid_decode.sv */
// Per-string decode state and the combinational result logic of the indexer.
// Depends on u8sid_pkg for the lead decode, masks and the result struct.
module u8sid_decode #(
  parameter int JUMP_STEP = u8sid_pkg::JUMP_STEP_DEF,
  parameter int MAX_BYTES = u8sid_pkg::MAX_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output logic                   emit,
  output u8sid_pkg::u8sid_res_t  res
);
  import u8sid_pkg::*;

  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int JW = (JUMP_STEP > 1) ? $clog2(JUMP_STEP) : 1;

  logic [CW-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [CW-1:0] pt_cnt_r, pt_cnt_nxt;
  logic [JW-1:0] jmp_cnt_r, jmp_cnt_nxt;
  logic [15:0]   seq_start_r, seq_start_nxt;
  logic [2:0]    exp_len_r, exp_len_nxt;
  logic [2:0]    rcv_r, rcv_nxt;
  logic [17:0]   acc_r, acc_nxt;
  logic [7:0]    lead_r, lead_nxt;
  logic          ovf_r, ovf_nxt;

  logic [2:0]    exp_len_s, rcv_s;
  logic [17:0]   acc_s;
  logic [7:0]    lead_s;
  logic [15:0]   start_s;
  logic [CW-1:0] byte_s, pt_s;
  logic          ovf_s, bad_s, done;
  logic          byte_full, pt_full;
  lead_info_t    li;
  logic [31:0]   off_ext, pt_ext, pt_s_ext;
  logic [20:0]   cp;

  assign li        = lead_decode(data_byte);
  assign byte_full = (byte_cnt_r >= CW'(MAX_BYTES));
  assign pt_full   = (pt_cnt_r >= CW'(MAX_BYTES));
  assign off_ext   = 32'(byte_cnt_r);
  assign pt_ext    = 32'(pt_cnt_r);

  always_comb begin
    ovf_s  = ovf_r | byte_full;
    byte_s = byte_full ? byte_cnt_r : byte_cnt_r + CW'(1);
    bad_s  = 1'b0;
    if (exp_len_r == LEN_NONE) begin
      exp_len_s = li.len;
      bad_s     = li.bad;
      lead_s    = data_byte;
      acc_s     = '0;
      rcv_s     = LEN_1;
      start_s   = (off_ext > 32'h0000_FFFF) ? 16'hFFFF : off_ext[15:0];
    end else begin
      exp_len_s = exp_len_r;
      lead_s    = lead_r;
      acc_s     = {acc_r[11:0], data_byte[5:0] & CONT_MASK[5:0]};
      rcv_s     = rcv_r + 3'd1;
      start_s   = seq_start_r;
    end
    done = (rcv_s >= exp_len_s) || last_byte;
  end

  // merge the held lead bits with the continuation payload
  always_comb begin
    case (rcv_s)
      LEN_2:   cp = {10'd0, lead_s[4:0] & LEAD2_MASK[4:0], acc_s[5:0]};
      LEN_3:   cp = {5'd0, lead_s[3:0] & LEAD3_MASK[3:0], acc_s[11:0]};
      LEN_4:   cp = {lead_s[2:0] & LEAD4_MASK[2:0], acc_s};
      default: cp = {13'd0, lead_s};
    endcase
  end

  always_comb begin
    pt_s        = (done && !pt_full) ? pt_cnt_r + CW'(1) : pt_cnt_r;
    pt_s_ext    = 32'(pt_s);
    jmp_cnt_nxt = jmp_cnt_r;
    if (done && !pt_full) begin
      jmp_cnt_nxt = (jmp_cnt_r == JW'(JUMP_STEP - 1)) ? '0 : jmp_cnt_r + JW'(1);
    end

    emit                  = done;
    res.code_point        = cp;
    res.code_point_index  = (pt_ext > 32'h0000_FFFF) ? 16'hFFFF : pt_ext[15:0];
    res.start_offset      = start_s;
    res.jump_mark         = (pt_cnt_r != '0) && (jmp_cnt_r == '0);
    res.invalid_lead      = bad_s;
    res.truncated         = rcv_s < exp_len_s;
    res.string_end        = last_byte;
    res.total_code_points = '0;
    res.all_ascii         = 1'b0;
    res.count_saturated   = ovf_s;
    if (last_byte) begin
      res.total_code_points = (pt_s_ext > 32'h0001_FFFF) ? 17'h1FFFF : pt_s_ext[16:0];
      res.all_ascii         = (pt_s == byte_s) && !ovf_s;
    end

    byte_cnt_nxt  = byte_s;
    pt_cnt_nxt    = pt_s;
    seq_start_nxt = start_s;
    exp_len_nxt   = done ? LEN_NONE : exp_len_s;
    rcv_nxt       = done ? 3'd0 : rcv_s;
    acc_nxt       = acc_s;
    lead_nxt      = lead_s;
    ovf_nxt       = ovf_s;
    // end of string: drop all per-string state
    if (last_byte) begin
      byte_cnt_nxt  = '0;
      pt_cnt_nxt    = '0;
      jmp_cnt_nxt   = '0;
      seq_start_nxt = '0;
      acc_nxt       = '0;
      lead_nxt      = '0;
      ovf_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r  <= '0;
      pt_cnt_r    <= '0;
      jmp_cnt_r   <= '0;
      seq_start_r <= '0;
      exp_len_r   <= LEN_NONE;
      rcv_r       <= '0;
      acc_r       <= '0;
      lead_r      <= '0;
      ovf_r       <= 1'b0;
    end else if (fire) begin
      byte_cnt_r  <= byte_cnt_nxt;
      pt_cnt_r    <= pt_cnt_nxt;
      jmp_cnt_r   <= jmp_cnt_nxt;
      seq_start_r <= seq_start_nxt;
      exp_len_r   <= exp_len_nxt;
      rcv_r       <= rcv_nxt;
      acc_r       <= acc_nxt;
      lead_r      <= lead_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

endmodule

/* src/u8sid_outq.sv */
// Two-entry result buffer that decouples the decode stage from the receiver.
// Depends on u8sid_pkg for the result struct.
module u8sid_outq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  u8sid_pkg::u8sid_res_t  push_res,
  output logic                   space,
  output logic                   out_valid,
  input  logic                   out_ready,
  output u8sid_pkg::u8sid_res_t  out_res
);
  import u8sid_pkg::*;

  u8sid_res_t  ent_r [2];
  logic        wptr_r, rptr_r;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign out_valid = (cnt_r != 2'd0);
  assign space     = (cnt_r != 2'd2);
  assign pop       = out_valid && out_ready;
  assign out_res   = ent_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wptr_r] <= push_res;
  end

endmodule

/* tb/tb_utf8_stream_indexer_decoder_unit.sv */
// Self-checking testbench for utf8_stream_indexer_decoder_unit: drives byte strings on in_,
// predicts each code point result in a local decoder, and checks every out_ transfer.
// Depends on u8sid_pkg and the RTL in src; needs no files or arguments.
module tb_utf8_stream_indexer_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import u8sid_pkg::*;

  localparam int JSTEP       = JUMP_STEP_DEF;
  localparam int MAXB        = MAX_BYTES_DEF;
  localparam int CYCLE_LIMIT = 1_500_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tlast = 1'b0;    // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [20:0] code_point, [36:21] code_point_index, [52:37] start_offset,
  // [69:53] total_code_points, [70] all_ascii, [71] count_saturated
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;          // [0] jump_mark, [1] invalid_lead, [2] truncated
  logic        out_tlast;          // string_end

  utf8_stream_indexer_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder state mirrored from the block
  logic [16:0] bytes_seen  = '0;
  logic [16:0] points_seen = '0;
  logic [15:0] seq_offset  = '0;
  logic [2:0]  seq_len     = LEN_NONE;
  logic [2:0]  seq_got     = '0;
  logic [17:0] seq_bits    = '0;
  logic [7:0]  seq_lead    = '0;
  logic        past_limit  = 1'b0;

  u8sid_res_t  expected_points[$];
  logic [7:0]  str_bytes[$];
  int          fail_count  = 0;
  int          cycle_count = 0;
  int          stall_level = 1;
  bit          gap_on      = 1'b1;
  int          ready_left  = 0;

  task automatic decode_byte(input logic [7:0] b, input logic fin,
                             output bit emit, output u8sid_res_t r);
    logic [16:0] here;
    logic        bad;
    logic        trunc;
    logic [20:0] cp;
    logic [16:0] idx;
    here  = bytes_seen;
    bad   = 1'b0;
    emit  = 1'b0;
    r     = '0;
    if (bytes_seen >= MAXB) past_limit = 1'b1;
    else bytes_seen = bytes_seen + 17'd1;
    if (seq_len == LEN_NONE) begin
      seq_lead   = b;
      seq_bits   = '0;
      seq_got    = 3'd1;
      seq_offset = (here > 17'hFFFF) ? 16'hFFFF : here[15:0];
      if (b < ASCII_LIMIT) seq_len = LEN_1;
      else if (b < LEAD2_LOW) begin
        seq_len = LEN_1;
        bad = 1'b1;
      end else if (b < LEAD3_LOW) seq_len = LEN_2;
      else if (b < LEAD4_LOW) seq_len = LEN_3;
      else if (b < LEAD_INV_LOW) seq_len = LEN_4;
      else begin
        seq_len = LEN_1;
        bad = 1'b1;
      end
    end else begin
      // continuation bits are taken as they come, no check on the top two
      seq_bits = {seq_bits[11:0], b[5:0]};
      seq_got  = seq_got + 3'd1;
    end
    if (seq_got < seq_len && !fin) return;

    trunc = seq_got < seq_len;
    case (seq_got)
      LEN_2:   cp = (21'(seq_lead & LEAD2_MASK) << 6) | 21'(seq_bits);
      LEN_3:   cp = (21'(seq_lead & LEAD3_MASK) << 12) | 21'(seq_bits);
      LEN_4:   cp = (21'(seq_lead & LEAD4_MASK) << 18) | 21'(seq_bits);
      default: cp = 21'(seq_lead);
    endcase
    idx = points_seen;
    if (points_seen < MAXB) points_seen = points_seen + 17'd1;
    seq_len = LEN_NONE;
    seq_got = '0;

    r.code_point       = cp;
    r.code_point_index = (idx > 17'hFFFF) ? 16'hFFFF : idx[15:0];
    r.start_offset     = seq_offset;
    r.jump_mark        = (idx != 0) && (idx % JSTEP == 0);
    r.invalid_lead     = bad;
    r.truncated        = trunc;
    r.string_end       = fin;
    r.count_saturated  = past_limit;
    if (fin) begin
      r.total_code_points = points_seen;
      r.all_ascii         = (points_seen == bytes_seen) && !past_limit;
      bytes_seen  = '0;
      points_seen = '0;
      seq_offset  = '0;
      seq_bits    = '0;
      seq_lead    = '0;
      past_limit  = 1'b0;
    end
    emit = 1'b1;
  endtask

  // Predict on every accepted input transfer
  always @(posedge clk) begin : byte_accept
    bit         emit;
    u8sid_res_t r;
    if (rst_n && in_tvalid && in_tready) begin
      decode_byte(in_tdata, in_tlast, emit, r);
      if (emit) expected_points.push_back(r);
    end
  end

  function automatic void check_field(input string fname, input logic [20:0] want,
                                      input logic [20:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    u8sid_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_points.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result transfer with nothing expected, tdata %0h", $realtime,
                   out_tdata);
      end else begin
        want = expected_points.pop_front();
        check_field("code_point", want.code_point, out_tdata[20:0]);
        check_field("code_point_index", 21'(want.code_point_index), 21'(out_tdata[36:21]));
        check_field("start_offset", 21'(want.start_offset), 21'(out_tdata[52:37]));
        check_field("total_code_points", 21'(want.total_code_points),
                    21'(out_tdata[69:53]));
        check_field("all_ascii", 21'(want.all_ascii), 21'(out_tdata[70]));
        check_field("count_saturated", 21'(want.count_saturated), 21'(out_tdata[71]));
        check_field("jump_mark", 21'(want.jump_mark), 21'(out_tuser[0]));
        check_field("invalid_lead", 21'(want.invalid_lead), 21'(out_tuser[1]));
        check_field("truncated", 21'(want.truncated), 21'(out_tuser[2]));
        check_field("string_end", 21'(want.string_end), 21'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("utf8_stream_indexer_decoder_unit verification failed");
      $finish;
    end
  end

  // Receiver: alternate ready runs and stalls; level 0 keeps it ready
  always @(negedge clk) begin
    if (ready_left > 0) ready_left--;
    else if (stall_level == 0) out_tready <= 1'b1;
    else if (out_tready) begin
      out_tready <= 1'b0;
      if (stall_level == 1)
        ready_left = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 2)
                                                  : $urandom_range(5, 30);
      else
        ready_left = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 8)
                                                  : $urandom_range(15, 60);
    end else begin
      out_tready <= 1'b1;
      ready_left = (stall_level == 1) ? $urandom_range(0, 15) : $urandom_range(0, 3);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int g;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (gap_on) begin
      g = $urandom_range(0, 99);
      g = (g < 65) ? 0 : (g < 93) ? $urandom_range(1, 3) : $urandom_range(6, 25);
      if (g > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_string();
    foreach (str_bytes[i]) send_byte(str_bytes[i], i == str_bytes.size() - 1);
    str_bytes.delete();
  endtask

  // Drop valid and hold until every expected result has been transferred
  task automatic wait_results_done();
    if (in_tvalid) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    while (expected_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] multi_lead(input int len);
    case (len)
      2:       return 8'($urandom_range(8'hC2, 8'hDF));
      3:       return 8'($urandom_range(8'hE0, 8'hEF));
      default: return 8'($urandom_range(8'hF0, 8'hF4));
    endcase
  endfunction

  // Append one character: mostly well-formed, some invalid leads, cut sequences, noise
  task automatic add_char(input int ascii_pct);
    int k;
    int len;
    int n;
    logic [7:0] lead;
    if ($urandom_range(0, 99) < ascii_pct) begin
      str_bytes.push_back(8'($urandom_range(0, 127)));
      return;
    end
    k = $urandom_range(0, 99);
    if (k < 70) begin
      len  = (k < 25) ? 2 : (k < 50) ? 3 : 4;
      lead = multi_lead(len);
      n    = len - 1;
    end else if (k < 82) begin
      lead = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hC1))
                                  : 8'($urandom_range(8'hF5, 8'hFF));
      n    = 0;
    end else if (k < 92) begin
      len  = $urandom_range(2, 4);
      lead = multi_lead(len);
      n    = $urandom_range(0, len - 2);
    end else begin
      lead = 8'($urandom_range(0, 255));
      n    = 0;
    end
    str_bytes.push_back(lead);
    repeat (n) str_bytes.push_back(cont_byte());
  endtask

  task automatic run_strings(input int byte_target, input int ascii_pct);
    int sent;
    int n;
    sent = 0;
    while (sent < byte_target) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 25);
      repeat (n) add_char(ascii_pct);
      sent += str_bytes.size();
      send_string();
      if ($urandom_range(0, 19) == 0) wait_results_done();
    end
  endtask

  task automatic test_directed();
    stall_level = 1;
    gap_on      = 1'b1;
    // ASCII and invalid-lead extremes, then the edges of each sequence length
    str_bytes = '{8'h00, 8'h7F, 8'h80, 8'hC1, 8'hF5, 8'hFF, 8'hC2, 8'h80, 8'hDF, 8'hBF,
                  8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                  8'h41};
    send_string();
    // strings cut short after one, two and three bytes of a sequence
    str_bytes = '{8'hC3};
    send_string();
    str_bytes = '{8'hE2, 8'h82};
    send_string();
    str_bytes = '{8'hF0, 8'h9F, 8'h98};
    send_string();
  endtask

  task automatic test_random_strings();
    stall_level = 1;
    gap_on      = 1'b1;
    run_strings(800, 35);
  endtask

  task automatic test_back_to_back();
    stall_level = 0;
    gap_on      = 1'b0;
    run_strings(350, 50);
  endtask

  task automatic test_backpressure();
    stall_level = 2;
    gap_on      = 1'b1;
    run_strings(350, 35);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_results_done();
    test_random_strings();
    wait_results_done();
    test_back_to_back();
    wait_results_done();
    test_backpressure();
    wait_results_done();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_points.size() == 0) begin
      $display("utf8_stream_indexer_decoder_unit verification clean");
    end else begin
      $display("utf8_stream_indexer_decoder_unit verification failed");
    end
    $finish;
  end

endmodule
